@@ design/rgbhsv_pkg.sv @@
// Shared types and constants for the RGB to HSV converter.
`default_nettype none

package rgbhsv_pkg;

  // Field widths.
  localparam int COMP_W = 8;
  localparam int HUE_W  = 15;

  // Divider geometry: the numerator stays below 2**RECIP_SHIFT, the quotient fits in QUO_W.
  localparam int NUM_W       = 20;
  localparam int QUO_W       = 12;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int DIV_LAT     = 4;

  // Front stages before the dividers plus the output register.
  localparam int PIPE_LAT = DIV_LAT + 3;

  // Hue angles in 1/64 degree.
  localparam logic [HUE_W-1:0] HUE_GREEN_OFS = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BLUE_OFS  = 15'd15360;
  localparam logic [HUE_W-1:0] HUE_FULL      = 15'd23040;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Per-pixel side information that travels alongside the dividers.
  typedef struct packed {
    sector_t           sector;
    logic              neg;
    logic              grey;
    logic [COMP_W-1:0] value;
  } hsv_meta_t;

endpackage

`default_nettype wire

@@ design/rgbhsv_div.sv @@
// Pipelined unsigned divider built from a reciprocal table, a multiply and one correction step.
`default_nettype none

module rgbhsv_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [rgbhsv_pkg::NUM_W-1:0]  in_num,
  input  wire logic [rgbhsv_pkg::COMP_W-1:0] in_den,
  output logic                               out_valid,
  output logic [rgbhsv_pkg::QUO_W-1:0]       out_quo
);
  import rgbhsv_pkg::*;

  localparam int DEPTH  = 2 ** COMP_W;
  localparam int PROD_W = QUO_W + COMP_W;

  // Reciprocal table floor(2**RECIP_SHIFT / d); a zero divisor maps to zero.
  logic [RECIP_W-1:0] recip_tab [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_recip
    localparam int DEN = (i == 0) ? 1 : i;
    localparam logic [RECIP_W-1:0] RV =
      (i == 0) ? '0 : RECIP_W'((1 << RECIP_SHIFT) / DEN);
    assign recip_tab[i] = RV;
  end

  logic                  va_r, vb_r, vc_r, vd_r;
  logic [NUM_W-1:0]      num_a_r, num_b_r, num_c_r;
  logic [COMP_W-1:0]     den_a_r, den_b_r, den_c_r;
  logic [RECIP_W-1:0]    rcp_a_r;
  logic [QUO_W-1:0]      q0_b_r, q0_c_r, quo_r;
  logic [PROD_W-1:0]     prod_c_r;
  logic [NUM_W+RECIP_W-1:0] est_nxt;
  logic [NUM_W:0]        bound_nxt;
  logic                  fix_nxt;

  assign est_nxt   = {{RECIP_W{1'b0}}, num_a_r} * {{NUM_W{1'b0}}, rcp_a_r};
  assign bound_nxt = {1'b0, prod_c_r} + {{(NUM_W + 1 - COMP_W){1'b0}}, den_c_r};
  // The estimate is low by at most one; bump it when the remainder still covers the divisor.
  assign fix_nxt   = (den_c_r != '0) && ({1'b0, num_c_r} >= bound_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    num_a_r  <= in_num;
    den_a_r  <= in_den;
    rcp_a_r  <= recip_tab[in_den];
    num_b_r  <= num_a_r;
    den_b_r  <= den_a_r;
    q0_b_r   <= est_nxt[RECIP_SHIFT +: QUO_W];
    num_c_r  <= num_b_r;
    den_c_r  <= den_b_r;
    q0_c_r   <= q0_b_r;
    prod_c_r <= {{COMP_W{1'b0}}, q0_b_r} * {{QUO_W{1'b0}}, den_b_r};
    quo_r    <= q0_c_r + {{(QUO_W - 1){1'b0}}, fix_nxt};
  end

  assign out_valid = vd_r;
  assign out_quo   = quo_r;

  // The reciprocal estimate must leave a remainder below twice the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r && (den_c_r != '0) |->
      ({1'b0, num_c_r} >= {1'b0, prod_c_r}) &&
      (({1'b0, num_c_r} - {1'b0, prod_c_r}) <
       {{(NUM_W - COMP_W){1'b0}}, den_c_r, 1'b0}))
    else $error("divider remainder out of range");

  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r && (den_c_r == '0) |=> out_quo == '0)
    else $error("divider quotient nonzero for zero divisor");

  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> ##DIV_LAT out_valid)
    else $error("divider result did not appear on time");

endmodule

`default_nettype wire

@@ design/rgb_to_hsv_converter.sv @@
// Top level of the pipelined RGB to HSV converter.
`default_nettype none

// An accepted pixel passes through the stage 1 and stage 2 registers, the divider pipelines
// and the output register; out_valid then rises together with the result.
// Throughput: one pixel per clock cycle, set by the fully pipelined reciprocal dividers.
// busy is always low; the receiver cannot stall and the pipeline never needs to.
// Reset (rst_n low, synchronous) clears every valid bit so no transaction is reported;
// data registers are not reset.
module rgb_to_hsv_converter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [rgbhsv_pkg::COMP_W-1:0] in_red,
  input  wire logic [rgbhsv_pkg::COMP_W-1:0] in_green,
  input  wire logic [rgbhsv_pkg::COMP_W-1:0] in_blue,
  output logic                               out_valid,
  output logic [rgbhsv_pkg::HUE_W-1:0]       out_hue,
  output logic [rgbhsv_pkg::COMP_W-1:0]      out_saturation,
  output logic [rgbhsv_pkg::COMP_W-1:0]      out_value
);
  import rgbhsv_pkg::*;

  // Every cycle can take a new transaction, so the converter never reports busy.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage 1: find the maximum and minimum, pick the sector and form |difference|.
  // Ties go to red first, then green, as in the usual definition.
  // ---------------------------------------------------------------------------
  logic              red_max, green_max;
  logic [COMP_W-1:0] hi_nxt, lo_nxt, pos_nxt, sub_nxt, mag_nxt;
  hsv_meta_t         meta1_nxt;

  assign red_max   = (in_red >= in_green) && (in_red >= in_blue);
  assign green_max = !red_max && (in_green >= in_blue);

  always_comb begin
    if (red_max) begin
      hi_nxt           = in_red;
      pos_nxt          = in_green;
      sub_nxt          = in_blue;
      meta1_nxt.sector = SEC_RED;
    end else if (green_max) begin
      hi_nxt           = in_green;
      pos_nxt          = in_blue;
      sub_nxt          = in_red;
      meta1_nxt.sector = SEC_GREEN;
    end else begin
      hi_nxt           = in_blue;
      pos_nxt          = in_red;
      sub_nxt          = in_green;
      meta1_nxt.sector = SEC_BLUE;
    end
    lo_nxt = (in_red <= in_green) ? in_red : in_green;
    if (in_blue < lo_nxt) begin
      lo_nxt = in_blue;
    end
    meta1_nxt.neg   = pos_nxt < sub_nxt;
    meta1_nxt.grey  = hi_nxt == lo_nxt;
    meta1_nxt.value = hi_nxt;
    mag_nxt = meta1_nxt.neg ? (sub_nxt - pos_nxt) : (pos_nxt - sub_nxt);
  end

  logic              v1_r;
  hsv_meta_t         meta1_r;
  logic [COMP_W-1:0] delta1_r, mag1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    meta1_r  <= meta1_nxt;
    delta1_r <= hi_nxt - lo_nxt;
    mag1_r   <= mag_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: numerators. Hue needs 3840*|difference| (4096x - 256x) and
  // saturation needs 255*delta (256x - x); both are shift-and-subtract.
  // ---------------------------------------------------------------------------
  logic [NUM_W-1:0] nh_nxt, ns_nxt;

  assign nh_nxt = {mag1_r, 12'b0} - {4'b0, mag1_r, 8'b0};
  assign ns_nxt = {{(NUM_W - COMP_W - 8){1'b0}}, delta1_r, 8'b0}
                - {{(NUM_W - COMP_W){1'b0}}, delta1_r};

  logic              v2_r;
  hsv_meta_t         meta2_r;
  logic [COMP_W-1:0] delta2_r;
  logic [NUM_W-1:0]  nh2_r, ns2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    meta2_r  <= meta1_r;
    delta2_r <= delta1_r;
    nh2_r    <= nh_nxt;
    ns2_r    <= ns_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stages 3 to 6: the two divisions run in parallel.
  // The side information follows in a matching delay line.
  // ---------------------------------------------------------------------------
  logic             hv_valid, sv_valid;
  logic [QUO_W-1:0] hq, sq;

  rgbhsv_div u_hue_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_num    (nh2_r),
    .in_den    (delta2_r),
    .out_valid (hv_valid),
    .out_quo   (hq)
  );

  rgbhsv_div u_sat_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_num    (ns2_r),
    .in_den    (meta2_r.value),
    .out_valid (sv_valid),
    .out_quo   (sq)
  );

  hsv_meta_t meta_dl_r [DIV_LAT];

  always_ff @(posedge clk) begin
    meta_dl_r[0] <= meta2_r;
    for (int i = 1; i < DIV_LAT; i++) begin
      meta_dl_r[i] <= meta_dl_r[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: place the hue offset in its sector and wrap negative red hues.
  // A grey pixel forces hue and saturation to zero.
  // ---------------------------------------------------------------------------
  hsv_meta_t         meta_o;
  logic [HUE_W-1:0]  hq_ext, hue_nxt;
  logic [COMP_W-1:0] sat_nxt;

  assign meta_o = meta_dl_r[DIV_LAT-1];
  assign hq_ext = {{(HUE_W - QUO_W){1'b0}}, hq};

  always_comb begin
    case (meta_o.sector)
      SEC_RED: begin
        hue_nxt = (meta_o.neg && (hq != '0)) ? (HUE_FULL - hq_ext) : hq_ext;
      end
      SEC_GREEN: begin
        hue_nxt = meta_o.neg ? (HUE_GREEN_OFS - hq_ext) : (HUE_GREEN_OFS + hq_ext);
      end
      SEC_BLUE: begin
        hue_nxt = meta_o.neg ? (HUE_BLUE_OFS - hq_ext) : (HUE_BLUE_OFS + hq_ext);
      end
      default: begin
        hue_nxt = '0;
      end
    endcase
    sat_nxt = sq[COMP_W-1:0];
    if (meta_o.grey) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end
  end

  logic              out_valid_r;
  logic [HUE_W-1:0]  hue_r;
  logic [COMP_W-1:0] sat_r, value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= hv_valid && sv_valid;
    end
  end

  always_ff @(posedge clk) begin
    hue_r   <= hue_nxt;
    sat_r   <= sat_nxt;
    value_r <= meta_o.value;
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_value      = value_r;

  // Every accepted transaction produces a result, and nothing else does.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##PIPE_LAT out_valid)
    else $error("accepted pixel did not produce a result on time");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##PIPE_LAT !out_valid)
    else $error("result produced without an accepted pixel");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue < HUE_FULL)
    else $error("hue out of range");

  // Saturation is zero only for a grey pixel, which must also give hue zero.
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_saturation == '0) |-> out_hue == '0)
    else $error("grey pixel with nonzero hue");

endmodule

`default_nettype wire
